// ===== hw/rtl/rrfr_pkg.sv =====
package rrfr_pkg;

  localparam int EPC_BYTES = 12;
  localparam int MAX_FRAME = 256;
  localparam int EPC_W = 8 * EPC_BYTES;
  localparam int EPC_IDX_W = (EPC_BYTES > 1) ? $clog2(EPC_BYTES) : 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] HEADER_BYTE = 8'hA0;
  localparam logic [7:0] CMD_INV_BUF = 8'h90;
  localparam logic [7:0] CMD_REAL_TIME = 8'h89;
  localparam logic [7:0] CMD_FAST_SWITCH = 8'h8A;
  localparam logic [7:0] CMD_BEEPER = 8'h7A;

  localparam logic [7:0] LEN_MIN = 8'd2;
  localparam logic [7:0] LEN_SHORT_REPLY = 8'h04;
  localparam logic [7:0] LEN_ANT_ABSENT = 8'h05;
  localparam logic [7:0] LEN_SUMMARY = 8'h0A;
  localparam logic [7:0] LEN_EPC_MIN = 8'd18;

  localparam logic [7:0] OFF_INV_BUF = 8'd6;
  localparam logic [7:0] OFF_REAL_TIME = 8'd4;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CHECKSUM   = 3'd1,
    ST_OVERSIZE   = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_CMD_ERR    = 3'd4,
    ST_ANT_ABSENT = 3'd5,
    ST_LEN_ERR    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REC_OVERSIZE,
    REC_SHORT,
    REC_FRAME
  } rec_kind_t;

  // one finished or rejected frame, handed from parser to classifier
  typedef struct packed {
    rec_kind_t        kind;
    logic             sum_ok;
    logic [7:0]       len;
    logic [7:0]       cmd;
    logic [7:0]       addr;
    logic [7:0]       detail;
    logic [EPC_W-1:0] epc;
  } rec_t;

  // data offset of the tag identifier, zero when the command carries none
  function automatic logic [7:0] epc_offset(input logic [7:0] cmd);
    logic [7:0] off;
    off = 8'd0;
    if (cmd == CMD_INV_BUF) begin
      off = OFF_INV_BUF;
    end else if (cmd == CMD_REAL_TIME || cmd == CMD_FAST_SWITCH) begin
      off = OFF_REAL_TIME;
    end
    return off;
  endfunction

endpackage

// ===== hw/rtl/rrfr_front.sv =====
module rrfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_fire,
  input  logic [7:0]    rx_byte,
  output logic          rec_push,
  output rrfr_pkg::rec_t rec
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] det_r, det_nxt;

  logic [7:0] store_r [rrfr_pkg::EPC_BYTES];

  logic [7:0]                     sum_add;
  logic [7:0]                     data_idx;
  logic [7:0]                     off;
  logic [7:0]                     rel;
  logic                           last_byte;
  logic                           store_we;
  logic [rrfr_pkg::EPC_IDX_W-1:0] store_idx;
  logic [rrfr_pkg::EPC_W-1:0]     epc_flat;

  assign sum_add   = 8'(sum_r + rx_byte);
  assign data_idx  = 8'(pos_r - 8'd1);
  assign off       = rrfr_pkg::epc_offset(cmd_r);
  assign rel       = 8'(data_idx - off);
  assign last_byte = (9'(pos_r) + 9'd1) >= 9'(len_r);
  assign store_idx = rel[rrfr_pkg::EPC_IDX_W-1:0];
  assign store_we  = byte_fire && (phase_r == PH_BODY) && !last_byte && (pos_r != 8'd0) &&
                     (data_idx != 8'd0) && (off != 8'd0) && (data_idx >= off) &&
                     (rel < 8'(rrfr_pkg::EPC_BYTES));

  always_comb begin
    for (int i = 0; i < rrfr_pkg::EPC_BYTES; i++) begin
      epc_flat[rrfr_pkg::EPC_W-1-8*i -: 8] = store_r[i];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    det_nxt   = det_r;
    rec_push  = 1'b0;
    rec       = '0;
    rec.kind  = rrfr_pkg::REC_FRAME;
    if (byte_fire) begin
      case (phase_r)
        PH_LEN: begin
          len_nxt  = rx_byte;
          addr_nxt = 8'd0;
          cmd_nxt  = 8'd0;
          det_nxt  = 8'd0;
          if ((10'(rx_byte) + 10'd2) > 10'(rrfr_pkg::MAX_FRAME)) begin
            phase_nxt = PH_HUNT;
            rec_push  = 1'b1;
            rec.kind  = rrfr_pkg::REC_OVERSIZE;
          end else if (rx_byte < rrfr_pkg::LEN_MIN) begin
            phase_nxt = PH_HUNT;
            rec_push  = 1'b1;
            rec.kind  = rrfr_pkg::REC_SHORT;
          end else begin
            sum_nxt   = sum_add;
            pos_nxt   = 8'd0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (last_byte) begin
            // check byte: emit the whole frame
            phase_nxt  = PH_HUNT;
            rec_push   = 1'b1;
            rec.sum_ok = (sum_add == 8'd0);
            rec.len    = len_r;
            rec.cmd    = cmd_r;
            rec.addr   = addr_r;
            rec.detail = det_r;
            rec.epc    = epc_flat;
          end else begin
            if (pos_r == 8'd0) begin
              addr_nxt = rx_byte;
            end else if (data_idx == 8'd0) begin
              cmd_nxt = rx_byte;
            end else if (data_idx == 8'd1) begin
              det_nxt = rx_byte;
            end
            sum_nxt = sum_add;
            pos_nxt = 8'(pos_r + 8'd1);
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == rrfr_pkg::HEADER_BYTE) begin
            sum_nxt   = rrfr_pkg::HEADER_BYTE;
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 8'd0;
      pos_r   <= 8'd0;
      sum_r   <= 8'd0;
      addr_r  <= 8'd0;
      cmd_r   <= 8'd0;
      det_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      det_r   <= det_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= rx_byte;
    end
  end

endmodule

// ===== hw/rtl/rrfr_queue.sv =====
module rrfr_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  rrfr_pkg::rec_t                push_rec,
  input  logic                          pop,
  output logic                          q_valid,
  output logic                          q_full,
  output rrfr_pkg::rec_t                head,
  output logic [rrfr_pkg::Q_CNT_W-1:0]  count
);

  rrfr_pkg::rec_t slot_r [rrfr_pkg::Q_DEPTH];

  logic [rrfr_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrfr_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrfr_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == rrfr_pkg::Q_CNT_W'(rrfr_pkg::Q_DEPTH));
  assign head    = slot_r[rd_ptr_r];
  assign count   = cnt_r;
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rrfr_pkg::Q_PTR_W'(rrfr_pkg::Q_DEPTH - 1)) ?
                   '0 : rrfr_pkg::Q_PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rrfr_pkg::Q_PTR_W'(rrfr_pkg::Q_DEPTH - 1)) ?
                   '0 : rrfr_pkg::Q_PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = rrfr_pkg::Q_CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = rrfr_pkg::Q_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== hw/rtl/rrfr_back.sv =====
module rrfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rrfr_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_status,
  output logic [7:0]     out_command,
  output logic [7:0]     out_reader_address,
  output logic [7:0]     out_detail,
  output logic           out_epc_valid,
  output logic [31:0]    out_epc_upper,
  output logic [63:0]    out_epc_lower
);

  logic        valid_r, valid_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  det_r, det_nxt;
  logic        epc_valid_r, epc_valid_nxt;
  logic [95:0] epc_r, epc_nxt;

  logic        load;
  logic        want_epc;
  logic        epc_fits;
  logic        epc_nonzero;
  logic [2:0]  status_c;

  assign load        = q_valid && (!valid_r || !out_stall);
  assign q_pop       = load;
  assign epc_fits    = (10'(rrfr_pkg::epc_offset(q_rec.cmd)) + 10'(rrfr_pkg::EPC_BYTES)) <=
                       (10'(q_rec.len) - 10'd2);
  assign epc_nonzero = |q_rec.epc;

  always_comb begin
    status_c = rrfr_pkg::ST_OK;
    want_epc = 1'b0;
    case (q_rec.kind)
      rrfr_pkg::REC_OVERSIZE: status_c = rrfr_pkg::ST_OVERSIZE;
      rrfr_pkg::REC_SHORT:    status_c = rrfr_pkg::ST_TOO_SHORT;
      default: begin
        if (!q_rec.sum_ok) begin
          status_c = rrfr_pkg::ST_CHECKSUM;
        end else if (q_rec.len != rrfr_pkg::LEN_MIN) begin
          case (q_rec.cmd)
            rrfr_pkg::CMD_INV_BUF: begin
              if (q_rec.len == rrfr_pkg::LEN_SHORT_REPLY) status_c = rrfr_pkg::ST_CMD_ERR;
              else want_epc = 1'b1;
            end
            rrfr_pkg::CMD_REAL_TIME: begin
              if (q_rec.len == rrfr_pkg::LEN_SUMMARY) status_c = rrfr_pkg::ST_CMD_ERR;
              else want_epc = 1'b1;
            end
            rrfr_pkg::CMD_FAST_SWITCH: begin
              if (q_rec.len == rrfr_pkg::LEN_SHORT_REPLY) begin
                status_c = rrfr_pkg::ST_CMD_ERR;
              end else if (q_rec.len == rrfr_pkg::LEN_ANT_ABSENT) begin
                status_c = rrfr_pkg::ST_ANT_ABSENT;
              end else if (q_rec.len == rrfr_pkg::LEN_SUMMARY) begin
                status_c = rrfr_pkg::ST_OK;
              end else if (q_rec.len > rrfr_pkg::LEN_EPC_MIN) begin
                want_epc = 1'b1;
              end else begin
                status_c = rrfr_pkg::ST_LEN_ERR;
              end
            end
            rrfr_pkg::CMD_BEEPER: begin
              if (q_rec.len != rrfr_pkg::LEN_SHORT_REPLY) status_c = rrfr_pkg::ST_CMD_ERR;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    valid_nxt     = valid_r;
    status_nxt    = status_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    det_nxt       = det_r;
    epc_valid_nxt = epc_valid_r;
    epc_nxt       = epc_r;
    if (load) begin
      valid_nxt     = 1'b1;
      status_nxt    = status_c;
      cmd_nxt       = q_rec.cmd;
      addr_nxt      = q_rec.addr;
      det_nxt       = q_rec.detail;
      epc_valid_nxt = want_epc && epc_fits && epc_nonzero;
      epc_nxt       = (want_epc && epc_fits && epc_nonzero) ? 96'(q_rec.epc) : 96'd0;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    status_r    <= status_nxt;
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    det_r       <= det_nxt;
    epc_valid_r <= epc_valid_nxt;
    epc_r       <= epc_nxt;
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_command        = cmd_r;
  assign out_reader_address = addr_r;
  assign out_detail         = det_r;
  assign out_epc_valid      = epc_valid_r;
  assign out_epc_upper      = epc_r[95:64];
  assign out_epc_lower      = epc_r[63:0];

endmodule

// ===== hw/rtl/reader_response_frame_receiver_unit.sv =====
// Throughput: one received byte per cycle, sustained while results are taken.
// Result path: a frame's record enters the frame queue when the transaction
//   that carries its check byte (or its rejected length byte) is accepted; the output register then shows it.
// Two-entry frame queue between parser and classifier; in_stall rises only when
//   it is full, i.e. when the result side has stalled for several frames.
// Reset (rst_n low, synchronous): parser hunts for a header, queue and output empty.
module reader_response_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_command,
  output logic [7:0]  out_reader_address,
  output logic [7:0]  out_detail,
  output logic        out_epc_valid,
  output logic [31:0] out_epc_upper,
  output logic [63:0] out_epc_lower
);

  logic                         byte_fire;
  logic                         rec_push;
  rrfr_pkg::rec_t               rec;
  logic                         q_valid;
  logic                         q_full;
  logic                         q_pop;
  rrfr_pkg::rec_t               q_head;
  logic [rrfr_pkg::Q_CNT_W-1:0] q_count;

  // Hold off the link only when the queue cannot take a frame record; every
  // byte may end a frame, so stall them all rather than track which would.
  assign in_stall  = q_full;
  assign byte_fire = in_valid && !in_stall;

  // Front: header hunt, length check, running sum and identifier capture.
  rrfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (in_rx_byte),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // Queue: decouple the byte stream from result delivery.
  rrfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (q_head),
    .count    (q_count)
  );

  // Back: classify by record kind, checksum, command and length, drive the output register.
  rrfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rec              (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_command        (out_command),
    .out_reader_address (out_reader_address),
    .out_detail         (out_detail),
    .out_epc_valid      (out_epc_valid),
    .out_epc_upper      (out_epc_upper),
    .out_epc_lower      (out_epc_lower)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= rrfr_pkg::Q_CNT_W'(rrfr_pkg::Q_DEPTH))
    else $error("frame queue count beyond depth");

  a_epc_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_epc_valid |-> out_epc_upper == 32'd0 && out_epc_lower == 64'd0)
    else $error("identifier bits set without epc_valid");

  a_reject_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rrfr_pkg::ST_OVERSIZE || out_status == rrfr_pkg::ST_TOO_SHORT)
    |-> out_command == 8'd0 && out_reader_address == 8'd0 && out_detail == 8'd0 &&
        !out_epc_valid)
    else $error("rejected length carries frame fields");

  a_epc_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_epc_valid |-> out_status == rrfr_pkg::ST_OK)
    else $error("identifier reported on a failed frame");

endmodule
